/* rtl/core/led_matrix_bitplane_scanner_macros.svh */
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scanner_macros
// assertion macros for the led matrix bitplane scanner, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_BITPLANE_SCANNER_MACROS_SVH
`define LED_MATRIX_BITPLANE_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LMBS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmbs: assertion failed");
// next-cycle implication
`define LMBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmbs: assertion failed");
`else
`define LMBS_ASSERT_IMPL(label, ante, cons)
`define LMBS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/lmbs_pkg.sv */
// ----------------------------------------------------------------------------
// lmbs_pkg
// shared types and constants of the led matrix bitplane scanner
// ----------------------------------------------------------------------------
package lmbs_pkg;

    localparam int SLOT_CNT_W  = 6;
    localparam int PLANE_W     = 3;
    localparam int ROW_W       = 4;
    localparam int QUOT_W      = 5;
    localparam int SLOT_IDX_W  = 7;
    localparam int SHIFT_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [SHIFT_W-1:0] PERIOD_SHIFT_RESET = 4'd7;
    localparam logic [7:0]         BLANK_FRAME_BYTE   = 8'h01;

    // stream tuser codes
    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_TICK       = 1'b1;
    localparam logic KIND_COLUMN   = 1'b0;
    localparam logic KIND_SWAPPED  = 1'b1;

    typedef struct packed {
        logic                  notice;
        logic                  half;
        logic                  pristine;
        logic [7:0]            row_en;
        logic [15:0]           hold;
        logic [SLOT_IDX_W-1:0] slot;
    } lmbs_cmd_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  col;
        logic [7:0]  row_en;
        logic [15:0] hold;
        logic        last;
    } lmbs_item_t;

    typedef struct packed {
        logic busy;
        logic half;
    } lmbs_bk_stat_t;

    typedef struct packed {
        logic wr_en;
        logic wr_half;
        logic fence;
    } lmbs_fe_stat_t;

endpackage

/* rtl/core/lmbs_frame_mem.sv */
// ----------------------------------------------------------------------------
// lmbs_frame_mem
// simple dual-port frame store, one write port and one registered read port
// ----------------------------------------------------------------------------
module lmbs_frame_mem #(
    parameter int DEPTH = 1536,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/lmbs_cmd_queue.sv */
// ----------------------------------------------------------------------------
// lmbs_cmd_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module lmbs_cmd_queue
    import lmbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lmbs_cmd_t push_cmd,
    input  logic      pop,
    output lmbs_cmd_t head_cmd,
    output logic      full,
    output logic      empty
);

    lmbs_cmd_t             q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/core/lmbs_front.sv */
// ----------------------------------------------------------------------------
// lmbs_front
// input side: frame loading, frame swap, slot sequencing and command issue
// ----------------------------------------------------------------------------
module lmbs_front
    import lmbs_pkg::*;
#(
    parameter int FRAME_BYTES = 768,
    parameter int ROW_COUNT   = 8,
    parameter int MEM_AW      = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SHIFT_W-1:0] cfg_data,
    input  logic               q_full,
    input  logic               q_empty,
    input  lmbs_bk_stat_t      bk_stat,
    output logic               q_push,
    output lmbs_cmd_t          q_cmd,
    output logic [MEM_AW-1:0]  wr_addr,
    output logic [7:0]         wr_data,
    output lmbs_fe_stat_t      fe_stat
);

    localparam int PTR_W = $clog2(FRAME_BYTES);

    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic                  front_sel_reg, front_sel_next;
    logic                  swapped_reg, swapped_next;
    logic                  fence_reg, fence_next;
    logic [SLOT_CNT_W-1:0] slot_cnt_reg, slot_cnt_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic [ROW_W-1:0]      rmod_reg, rmod_next;
    logic [PLANE_W-1:0]    plane_reg, plane_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [SHIFT_W-1:0]    shift_reg, shift_next;

    logic                  accept;
    logic                  load_acc;
    logic                  tick_acc;
    logic [PTR_W:0]        ptr_inc;
    logic                  frame_full;
    logic [4:0]            hold_amt;

    assign s_tready  = !q_full && !fence_reg;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign load_acc  = accept && (s_tuser == OP_LOAD);
    assign tick_acc  = accept && (s_tuser == OP_TICK);

    assign ptr_inc    = {1'b0, ptr_reg} + 1'b1;
    assign frame_full = (ptr_inc == (PTR_W+1)'(FRAME_BYTES));

    // back frame is the half not shown
    assign wr_addr = front_sel_reg ? MEM_AW'(ptr_reg)
                                   : MEM_AW'(FRAME_BYTES) + MEM_AW'(ptr_reg);
    assign wr_data = s_tdata;

    assign fe_stat.wr_en   = load_acc;
    assign fe_stat.wr_half = !front_sel_reg;
    assign fe_stat.fence   = fence_reg;

    assign hold_amt = 5'(plane_reg) + 5'(shift_reg);

    assign q_push          = (load_acc && frame_full) || tick_acc;
    assign q_cmd.notice    = (s_tuser == OP_LOAD);
    assign q_cmd.half      = front_sel_reg;
    assign q_cmd.pristine  = !swapped_reg;
    assign q_cmd.row_en    = 8'd1 << row_reg;
    assign q_cmd.hold      = 16'd1 << hold_amt;
    assign q_cmd.slot      = SLOT_IDX_W'(quot_reg[PLANE_W-1:0]) * SLOT_IDX_W'(ROW_COUNT)
                           + SLOT_IDX_W'(rmod_reg);

    always_comb
    begin
        ptr_next       = ptr_reg;
        front_sel_next = front_sel_reg;
        swapped_next   = swapped_reg;
        fence_next     = fence_reg;
        slot_cnt_next  = slot_cnt_reg;
        quot_next      = quot_reg;
        rmod_next      = rmod_reg;
        plane_next     = plane_reg;
        row_next       = row_reg;
        shift_next     = shift_reg;

        if (cfg_valid)
        begin
            shift_next = cfg_data;
        end

        // release once every queued run has left the back part
        if (fence_reg && q_empty && !bk_stat.busy)
        begin
            fence_next = 1'b0;
        end

        if (load_acc)
        begin
            if (frame_full)
            begin
                ptr_next       = '0;
                front_sel_next = !front_sel_reg;
                swapped_next   = 1'b1;
                fence_next     = 1'b1;
            end
            else
            begin
                ptr_next = ptr_inc[PTR_W-1:0];
            end
        end

        if (tick_acc)
        begin
            plane_next    = quot_reg[PLANE_W-1:0];
            row_next      = rmod_reg;
            slot_cnt_next = slot_cnt_reg + 1'b1;
            if (slot_cnt_next == '0)
            begin
                quot_next = '0;
                rmod_next = '0;
            end
            else if (rmod_reg == ROW_W'(ROW_COUNT - 1))
            begin
                quot_next = quot_reg + 1'b1;
                rmod_next = '0;
            end
            else
            begin
                rmod_next = rmod_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            front_sel_reg <= 1'b0;
            swapped_reg   <= 1'b0;
            fence_reg     <= 1'b0;
            slot_cnt_reg  <= '0;
            quot_reg      <= '0;
            rmod_reg      <= '0;
            plane_reg     <= '0;
            row_reg       <= '0;
            shift_reg     <= PERIOD_SHIFT_RESET;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            front_sel_reg <= front_sel_next;
            swapped_reg   <= swapped_next;
            fence_reg     <= fence_next;
            slot_cnt_reg  <= slot_cnt_next;
            quot_reg      <= quot_next;
            rmod_reg      <= rmod_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            shift_reg     <= shift_next;
        end
    end

endmodule

/* rtl/core/lmbs_back.sv */
// ----------------------------------------------------------------------------
// lmbs_back
// output side: slot address reduction, column byte streaming, swap notices, output skid
// ----------------------------------------------------------------------------
module lmbs_back
    import lmbs_pkg::*;
#(
    parameter int FRAME_BYTES = 768,
    parameter int SLOT_BYTES  = 12,
    parameter int MEM_AW      = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  lmbs_cmd_t         q_cmd,
    output logic              q_pop,
    output logic              rd_en,
    output logic [MEM_AW-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output lmbs_bk_stat_t     bk_stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int START_W = $clog2(128 * SLOT_BYTES);
    localparam int FB_W    = $clog2(FRAME_BYTES + 1);
    localparam int OFS_W   = (START_W > FB_W) ? START_W : FB_W;
    localparam int K_W     = $clog2(SLOT_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_REDUCE = 4'b0010,
        ST_STREAM = 4'b0100,
        ST_NOTICE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [OFS_W-1:0]  addr_reg, addr_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              half_reg, half_next;
    logic              prist_reg, prist_next;
    logic [7:0]        row_en_reg, row_en_next;
    logic [15:0]       hold_reg, hold_next;

    logic              pend_v_reg, pend_v_next;
    lmbs_item_t        pend_reg, pend_next;
    logic              pend_prist_reg, pend_prist_next;
    logic              out_v_reg, out_v_next;
    lmbs_item_t        out_reg, out_next;
    logic              skid_v_reg, skid_v_next;
    lmbs_item_t        skid_reg, skid_next;

    logic              pop;
    logic [1:0]        occ;
    logic [1:0]        occ_after;
    logic              issue_ok;
    logic              issue;
    lmbs_item_t        arr;
    logic              k_last;
    logic [OFS_W-1:0]  addr_inc;

    assign pop       = out_v_reg && m_tready;
    assign occ       = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(pend_v_reg);
    assign occ_after = occ - 2'(pop);
    assign issue_ok  = (occ_after < 2'd2);
    assign k_last    = (k_reg == K_W'(SLOT_BYTES - 1));
    assign addr_inc  = addr_reg + 1'b1;

    assign rd_en   = (state_reg == ST_STREAM) && issue_ok;
    assign rd_addr = half_reg ? MEM_AW'(FRAME_BYTES) + MEM_AW'(addr_reg)
                              : MEM_AW'(addr_reg);

    assign bk_stat.busy = (state_reg != ST_IDLE);
    assign bk_stat.half = half_reg;

    // item arriving from the read stage
    always_comb
    begin
        arr = pend_reg;
        if (pend_reg.kind == KIND_SWAPPED)
        begin
            arr.col = '0;
        end
        else if (pend_prist_reg)
        begin
            arr.col = BLANK_FRAME_BYTE;
        end
        else
        begin
            arr.col = rd_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        k_next          = k_reg;
        half_next       = half_reg;
        prist_next      = prist_reg;
        row_en_next     = row_en_reg;
        hold_next       = hold_reg;
        q_pop           = 1'b0;
        issue           = 1'b0;
        pend_next       = pend_reg;
        pend_prist_next = pend_prist_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    half_next   = q_cmd.half;
                    prist_next  = q_cmd.pristine;
                    row_en_next = q_cmd.row_en;
                    hold_next   = q_cmd.hold;
                    addr_next   = OFS_W'(q_cmd.slot) * OFS_W'(SLOT_BYTES);
                    k_next      = '0;
                    state_next  = q_cmd.notice ? ST_NOTICE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (addr_reg >= OFS_W'(FRAME_BYTES))
                begin
                    addr_next = addr_reg - OFS_W'(FRAME_BYTES);
                end
                else
                begin
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                if (issue_ok)
                begin
                    issue           = 1'b1;
                    pend_next.kind  = KIND_COLUMN;
                    pend_next.col   = '0;
                    pend_next.row_en = row_en_reg;
                    pend_next.hold  = hold_reg;
                    pend_next.last  = k_last;
                    pend_prist_next = prist_reg;
                    addr_next       = (addr_inc == OFS_W'(FRAME_BYTES)) ? '0 : addr_inc;
                    k_next          = k_reg + 1'b1;
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NOTICE:
            begin
                if (issue_ok)
                begin
                    issue            = 1'b1;
                    pend_next.kind   = KIND_SWAPPED;
                    pend_next.col    = '0;
                    pend_next.row_en = '0;
                    pend_next.hold   = '0;
                    pend_next.last   = 1'b1;
                    pend_prist_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // two-entry output buffer fed by the read stage
    always_comb
    begin
        pend_v_next = issue;
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;
        if (out_v_reg && !pop)
        begin
            if (!skid_v_reg)
            begin
                skid_next   = arr;
                skid_v_next = pend_v_reg;
            end
        end
        else
        begin
            if (skid_v_reg)
            begin
                out_next    = skid_reg;
                out_v_next  = 1'b1;
                skid_next   = arr;
                skid_v_next = pend_v_reg;
            end
            else
            begin
                out_next    = arr;
                out_v_next  = pend_v_reg;
                skid_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            k_reg      <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
            half_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
            half_reg   <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        prist_reg      <= prist_next;
        row_en_reg     <= row_en_next;
        hold_reg       <= hold_next;
        pend_reg       <= pend_next;
        pend_prist_reg <= pend_prist_next;
        out_reg        <= out_next;
        skid_reg       <= skid_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.hold, out_reg.row_en, out_reg.col};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

/* rtl/core/led_matrix_bitplane_scanner.sv */
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scanner
// double-buffered led matrix scanner with binary code modulation
// ----------------------------------------------------------------------------
// s_* stream: tuser 0 loads tdata into the next free byte of the back frame,
// tuser 1 is a display timer tick. cfg_* sets the 4-bit period shift (reset 7).
// m_* stream: tuser 0 is a column byte with row enable and hold period,
// tuser 1 is the frame swapped notice that follows the load filling the frame.
// a load gives no transfer unless it fills the frame; then one notice follows.
// a tick gives SLOT_BYTES transfers, tlast on the final one, one byte per cycle
// while the output buffer has room. a tick occupies the back part while it
// takes the command, folds the slot address, then issues one read per byte
// on the single frame memory read port.
// slots that land past the frame are folded back one frame length per fold step.
// after a frame swap, input waits until reads of the old front frame have
// drained. after reset the shown frame reads as 0x01 bytes until the first
// swap; no clearing pass runs. when m_tready is low, two results wait in the
// output buffer, the read stream pauses and the command queue keeps taking
// input until it is full.
// ----------------------------------------------------------------------------
`include "led_matrix_bitplane_scanner_macros.svh"

module led_matrix_bitplane_scanner
    import lmbs_pkg::*;
#(
    parameter int FRAME_BYTES = 768,
    parameter int ROW_COUNT   = 8,
    parameter int SLOT_BYTES  = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // column_byte, row_enable, hold_period
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int MEM_DEPTH = 2 * FRAME_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    logic              q_push;
    lmbs_cmd_t         q_cmd;
    logic              q_pop;
    lmbs_cmd_t         q_head;
    logic              q_full;
    logic              q_empty;
    logic [MEM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    lmbs_bk_stat_t     bk_stat;
    lmbs_fe_stat_t     fe_stat;

    lmbs_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .ROW_COUNT   (ROW_COUNT),
        .MEM_AW      (MEM_AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_empty   (q_empty),
        .bk_stat   (bk_stat),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .fe_stat   (fe_stat)
    );

    lmbs_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    lmbs_frame_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (fe_stat.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lmbs_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .SLOT_BYTES  (SLOT_BYTES),
        .MEM_AW      (MEM_AW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (q_head),
        .q_pop    (q_pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .bk_stat  (bk_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // swap notice always closes its run
    `LMBS_ASSERT_IMPL(a_notice_last, m_tvalid && m_tuser, m_tlast)
    // loads never land in the half a running slot reads
    `LMBS_ASSERT_IMPL(a_no_write_read_clash, fe_stat.wr_en && bk_stat.busy,
                      fe_stat.wr_half != bk_stat.half)
    `LMBS_ASSERT_IMPL(a_queue_no_overflow, q_push, !q_full)
    `LMBS_ASSERT_NEXT(a_fence_release, fe_stat.fence && q_empty && !bk_stat.busy, !fe_stat.fence)

endmodule

/* tb/tb_led_matrix_bitplane_scanner.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_matrix_bitplane_scanner
// self-checking bench for the double-buffered bitplane scanner: a tracker
// keeps its own copy of both frames, slot counter and period shift, predicts
// every column byte and swap notice per accepted transfer and checks the
// output stream in order, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_led_matrix_bitplane_scanner;
    import lmbs_pkg::*;

    localparam int FRAME_BYTES = 768;
    localparam int ROW_COUNT   = 8;
    localparam int SLOT_BYTES  = 12;
    localparam int CYCLE_LIMIT = 400000;

    class scan_tracker;
        logic [7:0]   frame_mem [0:2*FRAME_BYTES-1];
        bit           front_half;
        int unsigned  load_ptr;
        bit [5:0]     slot_cnt;
        bit [2:0]     shown_plane;
        bit [2:0]     shown_row;
        bit [3:0]     period_shift;
        lmbs_item_t   pending_results[$];
        int unsigned  swaps;
        int unsigned  failures;

        function new();
            for (int a = 0; a < FRAME_BYTES; a++)
            begin
                frame_mem[a] = BLANK_FRAME_BYTE;
                frame_mem[FRAME_BYTES + a] = 8'h00;
            end
            front_half   = 1'b0;
            load_ptr     = 0;
            slot_cnt     = '0;
            shown_plane  = '0;
            shown_row    = '0;
            period_shift = PERIOD_SHIFT_RESET;
            swaps        = 0;
            failures     = 0;
        endfunction

        function void note_item(logic op, logic [7:0] data);
            int unsigned back_base;
            int unsigned front_base;
            int unsigned start;
            logic [7:0]  row_bits;
            logic [31:0] hold_full;
            lmbs_item_t  r;
            if (op == OP_LOAD)
            begin
                back_base = front_half ? 0 : FRAME_BYTES;
                frame_mem[back_base + load_ptr] = data;
                load_ptr++;
                if (load_ptr >= FRAME_BYTES)
                begin
                    load_ptr   = 0;
                    front_half = !front_half;
                    swaps++;
                    r.kind   = KIND_SWAPPED;
                    r.col    = 8'h00;
                    r.row_en = 8'h00;
                    r.hold   = 16'h0000;
                    r.last   = 1'b1;
                    pending_results.push_back(r);
                end
            end
            else
            begin
                // row and period belong to the slot latched by the previous tick
                row_bits    = 8'd1 << shown_row;
                hold_full   = (32'd1 << shown_plane) << period_shift;
                shown_plane = 3'(slot_cnt / ROW_COUNT);
                shown_row   = 3'(slot_cnt % ROW_COUNT);
                start       = (shown_plane * ROW_COUNT + shown_row) * SLOT_BYTES;
                front_base  = front_half ? FRAME_BYTES : 0;
                for (int k = 0; k < SLOT_BYTES; k++)
                begin
                    r.kind   = KIND_COLUMN;
                    r.col    = frame_mem[front_base + (start + k) % FRAME_BYTES];
                    r.row_en = row_bits;
                    r.hold   = hold_full[15:0];
                    r.last   = (k == SLOT_BYTES - 1);
                    pending_results.push_back(r);
                end
                slot_cnt++;
            end
        endfunction

        function void check_result(logic kind, logic [31:0] data, logic last);
            lmbs_item_t seen;
            lmbs_item_t want;
            seen.kind   = kind;
            seen.col    = data[7:0];
            seen.row_en = data[15:8];
            seen.hold   = data[31:16];
            seen.last   = last;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected transfer: kind %0d col %02h row %02h hold %04h last %0d",
                             seen.kind, seen.col, seen.row_en, seen.hold, seen.last);
                return;
            end
            want = pending_results.pop_front();
            if (seen.kind !== want.kind || seen.col !== want.col ||
                seen.row_en !== want.row_en || seen.hold !== want.hold ||
                seen.last !== want.last)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected kind %0d col %02h row %02h hold %04h last %0d, got kind %0d col %02h row %02h hold %04h last %0d",
                             want.kind, want.col, want.row_en, want.hold, want.last,
                             seen.kind, seen.col, seen.row_en, seen.hold, seen.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    scan_tracker tracker = new();
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold = 0;
    int          cycle_count = 0;

    led_matrix_bitplane_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver side, long hold-off counted here
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata, m_tlast);
    end

    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        tracker.note_item(op, data);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_shift(input logic [3:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.period_shift = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int         burst_at;
        int         target;
        logic       op;
        logic [3:0] shift_val;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = OP_LOAD;
        cfg_valid = 1'b0;
        cfg_data  = 4'h0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // blank frame, reset shift, walk into plane one
        tx_idle_pct = 32;
        rx_idle_pct = 74;
        for (int n = 0; n < 10; n++)
            send_item(OP_TICK, n[0] ? 8'hff : 8'h00);
        wait_drained();
        // large shift truncates the period
        write_shift(4'd15);
        send_item(OP_TICK, 8'hff);
        send_item(OP_TICK, 8'h3c);
        wait_drained();
        write_shift(4'd0);
        send_item(OP_LOAD, 8'h00);
        send_item(OP_LOAD, 8'hff);
        send_item(OP_LOAD, 8'h5a);
        send_item(OP_LOAD, 8'ha5);
        send_item(OP_LOAD, 8'h80);
        send_item(OP_LOAD, 8'h7f);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'hff);

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            tx_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 74 : 0;
            rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 32 : 0;
            shift_val = (phase == 0) ? 4'd8 : (phase == 1) ? 4'd3 : 4'($urandom_range(0, 15));
            write_shift(shift_val);
            burst_at = $urandom_range(10, 130);
            for (int i = 0; i < 140; i++)
            begin
                if (i == burst_at)
                begin
                    // finish the back frame so it swaps
                    target = tracker.swaps + 1;
                    while (tracker.swaps < target)
                    begin
                        op = ($urandom_range(0, 99) < 3) ? OP_TICK : OP_LOAD;
                        send_item(op, random_byte());
                    end
                end
                if (phase == 2 && i == 60)
                    rx_hold = 400;
                if (phase == 1 && i == 100)
                    wait_drained();
                if (phase == 2 && i >= 60 && i < 90)
                    op = OP_TICK;
                else
                    op = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_LOAD;
                send_item(op, random_byte());
            end
        end

        wait_drained();
        repeat (32) @(posedge clk);
        tracker.failures += tracker.pending_results.size();
        if (tracker.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
